[src/ramr_pkg.sv]
// Shared types and command codes for the rational add/multiply/reduce unit.
// Used by the top level, its gcd and divider units and the testbench; depends on nothing else.
package ramr_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_MUL = 2'd1;
  localparam cmd_t CMD_EQ  = 2'd2;

  // Handshake of the iterative helper units.
  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[src/ramr_gcd.sv]
// Binary (shift and subtract) greatest common divisor, one step per cycle.
// Depends on ramr_pkg for the control and status structs.
module ramr_gcd #(
  parameter int CW = 33
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ramr_pkg::unit_ctrl_t  ctrl,
  input  logic [CW-1:0]         x,
  input  logic [CW-1:0]         y,
  output ramr_pkg::unit_stat_t  stat,
  output logic [CW-1:0]         g
);
  import ramr_pkg::*;

  localparam int KW = $clog2(CW);

  logic          run;
  logic          done;
  logic [CW-1:0] u;
  logic [CW-1:0] v;
  logic [KW-1:0] k;
  logic [CW-1:0] u_minus_v;
  logic [CW-1:0] v_minus_u;
  logic          u_ge_v;

  assign u_minus_v = u - v;
  assign v_minus_u = v - u;
  assign u_ge_v    = (u >= v);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !run) begin
        run <= 1'b1;
        u   <= x;
        v   <= y;
        k   <= '0;
      end else if (run) begin
        // Both operands are nonzero at start, so only a subtraction of
        // equal values can clear u; v then holds the odd part of the gcd.
        if (u == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
          g    <= v << k;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + KW'(1);
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u_ge_v) begin
          u <= u_minus_v >> 1;
        end else begin
          v <= v_minus_u >> 1;
        end
      end
    end
  end

  assign stat.busy = run;
  assign stat.done = done;

endmodule

[src/ramr_div.sv]
// Restoring divider, one quotient bit per cycle, shared for both reductions.
// Depends on ramr_pkg for the control and status structs.
module ramr_div #(
  parameter int CW = 33
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ramr_pkg::unit_ctrl_t  ctrl,
  input  logic [CW-1:0]         dividend,
  input  logic [CW-1:0]         divisor,
  output ramr_pkg::unit_stat_t  stat,
  output logic [CW-1:0]         quotient
);
  import ramr_pkg::*;

  localparam int CNTW = $clog2(CW);

  logic            run;
  logic            done;
  logic [CNTW-1:0] cnt;
  logic [CW-1:0]   q;
  logic [CW-1:0]   rem;
  logic [CW-1:0]   d;
  logic [CW:0]     trial;

  assign trial = {rem, q[CW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start && !run) begin
        run <= 1'b1;
        q   <= dividend;
        rem <= '0;
        d   <= divisor;
        cnt <= '0;
      end else if (run) begin
        // The remainder always stays below the divisor, so CW bits hold it.
        if (!trial[CW]) begin
          rem <= trial[CW-1:0];
          q   <= {q[CW-2:0], 1'b1};
        end else begin
          rem <= {rem[CW-2:0], q[CW-1]};
          q   <= {q[CW-2:0], 1'b0};
        end
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(CW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = q;
  assign stat.busy = run;
  assign stat.done = done;

endmodule

[src/rational_add_mul_reduce.sv]
// Rational add/multiply with gcd reduction, and raw equality compare.
// Compare and no-op go straight to the result; add and multiply build the products on one
// shared multiplier, then divide numerator and denominator by their gcd, computed at the
// internal width min(2*OPERAND_WIDTH+1, 64); a zero numerator or denominator skips reduction.
// One item at a time: busy stays high until done; the next item is taken in the done cycle.
// Synchronous active-high reset clears the sequencer and the strobe.
module rational_add_mul_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  ramr_pkg::cmd_t               cmd,
  input  logic [OPERAND_WIDTH-1:0]     a_num,
  input  logic [OPERAND_WIDTH-1:0]     a_den,
  input  logic [OPERAND_WIDTH-1:0]     b_num,
  input  logic [OPERAND_WIDTH-1:0]     b_den,
  output logic                         done,
  output logic [2*OPERAND_WIDTH:0]     res_num,
  output logic [2*OPERAND_WIDTH-1:0]   res_den,
  output logic                         is_equal
);
  import ramr_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int NW = 2 * W + 1;
  localparam int DW = 2 * W;
  // Internal width: a sum at the widest operands wraps at 64 bits.
  localparam int CW = (NW > 64) ? 64 : NW;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL1      = 4'd1;
  localparam logic [3:0] S_MUL2      = 4'd2;
  localparam logic [3:0] S_MUL3      = 4'd3;
  localparam logic [3:0] S_CHECK     = 4'd4;
  localparam logic [3:0] S_GCD_GO    = 4'd5;
  localparam logic [3:0] S_GCD_WAIT  = 4'd6;
  localparam logic [3:0] S_DIVN_GO   = 4'd7;
  localparam logic [3:0] S_DIVN_WAIT = 4'd8;
  localparam logic [3:0] S_DIVD_GO   = 4'd9;
  localparam logic [3:0] S_DIVD_WAIT = 4'd10;
  localparam logic [3:0] S_FIN       = 4'd11;

  logic [3:0]    state;
  cmd_t          cmd_q;
  logic [W-1:0]  an;
  logic [W-1:0]  ad;
  logic [W-1:0]  bn;
  logic [W-1:0]  bd;
  logic [CW-1:0] num;
  logic [CW-1:0] den;
  logic [CW-1:0] part;
  logic [CW-1:0] g;
  logic          eq;

  logic [W-1:0]  mul_a;
  logic [W-1:0]  mul_b;
  logic [DW-1:0] prod;

  unit_ctrl_t    gcd_ctrl;
  unit_stat_t    gcd_stat;
  logic [CW-1:0] gcd_out;
  unit_ctrl_t    div_ctrl;
  unit_stat_t    div_stat;
  logic [CW-1:0] div_q;
  logic [CW-1:0] div_in;

  // One multiplier, fed in turn with the partial products: three for an add, two for a multiply.
  always_comb begin
    unique case (state)
      S_MUL1: begin
        mul_a = an;
        mul_b = (cmd_q == CMD_ADD) ? bd : bn;
      end
      S_MUL2: begin
        mul_a = bn;
        mul_b = ad;
      end
      default: begin
        mul_a = ad;
        mul_b = bd;
      end
    endcase
  end

  assign prod = DW'(mul_a) * DW'(mul_b);

  assign gcd_ctrl.start = (state == S_GCD_GO);
  assign div_ctrl.start = (state == S_DIVN_GO) || (state == S_DIVD_GO);
  assign div_in         = (state == S_DIVD_GO) ? den : num;

  ramr_gcd #(.CW(CW)) u_gcd (
    .clk  (clk),
    .rst  (rst),
    .ctrl (gcd_ctrl),
    .x    (num),
    .y    (den),
    .stat (gcd_stat),
    .g    (gcd_out)
  );

  ramr_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (div_in),
    .divisor  (g),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            an    <= a_num;
            ad    <= a_den;
            bn    <= b_num;
            bd    <= b_den;
            num   <= '0;
            den   <= '0;
            eq    <= (cmd == CMD_EQ) && (a_num == b_num) && (a_den == b_den);
            if (cmd == CMD_ADD || cmd == CMD_MUL) begin
              state <= S_MUL1;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_MUL1: begin
          num   <= CW'(prod);
          state <= (cmd_q == CMD_ADD) ? S_MUL2 : S_MUL3;
        end
        S_MUL2: begin
          part  <= CW'(prod);
          state <= S_MUL3;
        end
        S_MUL3: begin
          den <= CW'(prod);
          if (cmd_q == CMD_ADD) begin
            num <= num + part;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          // A zero numerator or denominator is passed on unreduced.
          state <= (num == '0 || den == '0) ? S_FIN : S_GCD_GO;
        end
        S_GCD_GO: begin
          state <= S_GCD_WAIT;
        end
        S_GCD_WAIT: begin
          if (gcd_stat.done) begin
            g     <= gcd_out;
            state <= S_DIVN_GO;
          end
        end
        S_DIVN_GO: begin
          state <= S_DIVN_WAIT;
        end
        S_DIVN_WAIT: begin
          if (div_stat.done) begin
            num   <= div_q;
            state <= S_DIVD_GO;
          end
        end
        S_DIVD_GO: begin
          state <= S_DIVD_WAIT;
        end
        S_DIVD_WAIT: begin
          if (div_stat.done) begin
            den   <= div_q;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_num  <= NW'(num);
          res_den  <= DW'(den);
          is_equal <= eq;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE) || gcd_stat.busy || div_stat.busy;

endmodule

[sim/testbench.sv]
// Self-checking testbench for rational_add_mul_reduce: add, multiply and
// compare items checked against an in-bench predictor with gcd reduction.
// Depends on src/ramr_pkg.sv and src/rational_add_mul_reduce.sv.
`timescale 1ns / 1ps

module testbench;
  import ramr_pkg::*;

  localparam int OPW = 16;
  localparam int NUM_W = 2 * OPW + 1;
  localparam int DEN_W = 2 * OPW;
  localparam logic [OPW-1:0] OP_MAX = '1;
  localparam cmd_t CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 300;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             eq;
  } fraction_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic [OPW-1:0] a_num, a_den, b_num, b_den;
  logic done;
  logic [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;
  logic is_equal;

  fraction_result_t pending_results[$];
  int failures = 0;
  int results_checked = 0;
  int items_sent = 0;
  int n_add = 0, n_mul = 0, n_cmp = 0, n_other = 0, n_equal_seen = 0;
  int cycle_count = 0;
  bit no_gaps = 1'b0;

  rational_add_mul_reduce #(.OPERAND_WIDTH(OPW)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .done(done), .res_num(res_num), .res_den(res_den), .is_equal(is_equal)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Reduced sum or product of two fractions, or the raw equality flag.
  function automatic fraction_result_t reduce_fraction(cmd_t op, logic [OPW-1:0] an,
                                                        logic [OPW-1:0] ad,
                                                        logic [OPW-1:0] bn,
                                                        logic [OPW-1:0] bd);
    fraction_result_t r;
    logic [63:0] num, den, x, y, t;
    num = '0;
    den = '0;
    r.eq = 1'b0;
    if (op == CMD_ADD || op == CMD_MUL) begin
      if (op == CMD_ADD)
        num = 64'(an) * 64'(bd) + 64'(bn) * 64'(ad);
      else
        num = 64'(an) * 64'(bn);
      den = 64'(ad) * 64'(bd);
      // A zero numerator or zero denominator is passed through unreduced.
      if (num != 0 && den != 0) begin
        x = num;
        y = den;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        num = num / x;
        den = den / x;
      end
    end else if (op == CMD_EQ) begin
      r.eq = (an == bn) && (ad == bd);
    end
    r.num = num[NUM_W-1:0];
    r.den = den[DEN_W-1:0];
    return r;
  endfunction

  // Sends one item; returns at the edge where it was accepted, start left high.
  task automatic send_item(cmd_t op, logic [OPW-1:0] an, logic [OPW-1:0] ad,
                           logic [OPW-1:0] bn, logic [OPW-1:0] bd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (busy);
    pending_results.push_back(reduce_fraction(op, an, ad, bn, bd));
    items_sent++;
    case (op)
      CMD_ADD: n_add++;
      CMD_MUL: n_mul++;
      CMD_EQ:  n_cmp++;
      default: n_other++;
    endcase
  endtask

  // Holds off the sender until every outstanding result has arrived.
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: num=%0d den=%0d eq=%0b",
               res_num, res_den, is_equal);
        failures++;
      end else begin
        fraction_result_t exp_r;
        exp_r = pending_results.pop_front();
        results_checked++;
        if (is_equal === 1'b1) n_equal_seen++;
        if (res_num !== exp_r.num) begin
          $error("res_num: expected %0d, got %0d", exp_r.num, res_num);
          failures++;
        end
        if (res_den !== exp_r.den) begin
          $error("res_den: expected %0d, got %0d", exp_r.den, res_den);
          failures++;
        end
        if (is_equal !== exp_r.eq) begin
          $error("is_equal: expected %0b, got %0b", exp_r.eq, is_equal);
          failures++;
        end
      end
    end
  end

  // Operand drawn with a bias toward extremes, powers of two and small values.
  function automatic logic [OPW-1:0] draw_operand(bit nonzero);
    logic [OPW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = OP_MAX;
      2: v = OPW'(1) << $urandom_range(0, OPW - 1);
      3: v = OPW'($urandom_range(1, 16));
      default: v = OPW'($urandom);
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  task automatic test_directed_add();
    send_item(CMD_ADD, 0, 1, 0, 1);
    send_item(CMD_ADD, 0, OP_MAX, 0, 3);
    send_item(CMD_ADD, OP_MAX, 1, OP_MAX, 1);
    send_item(CMD_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_item(CMD_ADD, OP_MAX, OP_MAX - 1, OP_MAX - 1, OP_MAX);
    send_item(CMD_ADD, 1, 2, 1, 2);
  endtask

  task automatic test_directed_multiply();
    send_item(CMD_MUL, 0, 7, 5, 3);
    send_item(CMD_MUL, OP_MAX, 1, OP_MAX, 1);
    send_item(CMD_MUL, 2, 3, 3, 2);
    send_item(CMD_MUL, 1, OP_MAX, 1, OP_MAX);
    send_item(CMD_MUL, 12, 18, 10, 4);
  endtask

  task automatic test_directed_compare();
    send_item(CMD_EQ, 5, 9, 5, 9);
    send_item(CMD_EQ, OP_MAX, OP_MAX, OP_MAX, OP_MAX);
    send_item(CMD_EQ, 5, 9, 6, 9);
    send_item(CMD_EQ, 5, 9, 5, 8);
    send_item(CMD_EQ, 0, 1, 0, 2);
    send_item(CMD_EQ, 1, 2, 2, 4);
  endtask

  // No-op command and zero denominators, which bypass reduction.
  task automatic test_out_of_range();
    send_item(CMD_NONE, OP_MAX, 3, 7, OP_MAX);
    send_item(CMD_ADD, 6, 0, 4, 8);
    send_item(CMD_MUL, 6, 9, 4, 0);
    send_item(CMD_ADD, 0, 0, 0, 0);
    send_item(CMD_EQ, 3, 0, 3, 0);
    wait_results_drained();
  endtask

  task automatic test_random_fractions(int count);
    cmd_t op;
    logic [OPW-1:0] an, ad, bn, bd;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0, 1: op = CMD_ADD;
        2, 3: op = CMD_MUL;
        default: op = CMD_EQ;
      endcase
      an = draw_operand(1'b0);
      ad = draw_operand(1'b1);
      bn = draw_operand(1'b0);
      bd = draw_operand(1'b1);
      // About half of the compares use identical fractions so the flag is hit.
      if (op == CMD_EQ && $urandom_range(0, 1) == 1) begin
        bn = an;
        bd = ad;
      end
      send_item(op, an, ad, bn, bd);
      if ($urandom_range(0, 99) == 0) wait_results_drained();
    end
  endtask

  // Fractions built with shared factors so that the gcd step does real work.
  task automatic test_random_common_factors(int count);
    cmd_t op;
    int ka, kb;
    logic [OPW-1:0] an, ad, bn, bd;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 1) == 0) ? CMD_ADD : CMD_MUL;
      ka = $urandom_range(1, 255);
      kb = ($urandom_range(0, 2) == 0) ? ka : $urandom_range(1, 255);
      an = OPW'(ka * $urandom_range(0, 65535 / ka));
      ad = OPW'(ka * $urandom_range(1, 65535 / ka));
      bn = OPW'(kb * $urandom_range(0, 65535 / kb));
      bd = OPW'(kb * $urandom_range(1, 65535 / kb));
      send_item(op, an, ad, bn, bd);
    end
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    test_random_fractions(count);
    no_gaps = 1'b0;
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    cmd   = CMD_ADD;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_add();
    test_directed_multiply();
    test_directed_compare();
    test_out_of_range();
    test_random_fractions(700);
    wait_results_drained();
    test_random_common_factors(450);
    test_back_to_back(180);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d add, %0d multiply, %0d compare, %0d no-op.",
             items_sent, n_add, n_mul, n_cmp, n_other);
    $display("Checked %0d results (%0d equal flags), %0d mismatches.",
             results_checked, n_equal_seen, failures);
    if (failures == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
src/ramr_pkg.sv
src/ramr_gcd.sv
src/ramr_div.sv
src/rational_add_mul_reduce.sv
sim/testbench.sv
